// ===== rtl/alsu_pkg.sv =====
// Shared types, codes and condition evaluation for the load/store unit.
`timescale 1ns / 1ps

package alsu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned InDataW = 144;
  localparam int unsigned OutDataW = 136;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14
  } cond_t;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  localparam logic [3:0] BE_BYTE = 4'b0001;
  localparam logic [3:0] BE_HALF = 4'b0011;
  localparam logic [3:0] BE_WORD = 4'b1111;

  typedef struct packed {
    logic             command;
    logic [1:0]       access_size;
    logic             sign_extend;
    logic             pre_index;
    logic             write_back;
    logic             offset_up;
    logic [3:0]       condition;
    logic [3:0]       flags_nzcv;
    logic [WordW-1:0] base_value;
    logic [WordW-1:0] offset_value;
    logic [WordW-1:0] store_value;
    logic [WordW-1:0] memory_word;
  } req_t;

  typedef struct packed {
    logic             executed;
    logic [WordW-1:0] access_address;
    logic [3:0]       byte_enable;
    logic [WordW-1:0] store_bytes;
    logic [WordW-1:0] load_result;
    logic             base_update;
    logic [WordW-1:0] base_new_value;
    logic             user_access;
  } res_t;

  function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] nzcv);
    logic n;
    logic z;
    logic c;
    logic v;
    logic pass;
    n = nzcv[3];
    z = nzcv[2];
    c = nzcv[1];
    v = nzcv[0];
    unique case (cond)
      COND_EQ: pass = z;
      COND_NE: pass = !z;
      COND_CS: pass = c;
      COND_CC: pass = !c;
      COND_MI: pass = n;
      COND_PL: pass = !n;
      COND_VS: pass = v;
      COND_VC: pass = !v;
      COND_HI: pass = c && !z;
      COND_LS: pass = !c || z;
      COND_GE: pass = (n == v);
      COND_LT: pass = (n != v);
      COND_GT: pass = !z && (n == v);
      COND_LE: pass = z || (n != v);
      COND_AL: pass = 1'b1;
      default: pass = 1'b0;
    endcase
    return pass;
  endfunction

endpackage

// ===== rtl/alsu_exec.sv =====
// Address generation, data formatting and writeback for one load/store request.
`timescale 1ns / 1ps

module alsu_exec (
  input  alsu_pkg::req_t req,
  output alsu_pkg::res_t res
);
  import alsu_pkg::*;

  logic             pass;
  logic [WordW-1:0] off;
  logic [WordW-1:0] addr;
  logic [WordW-1:0] post_addr;
  logic [3:0]       be;
  logic [WordW-1:0] sdata;
  logic [WordW-1:0] ldata;

  assign pass = cond_pass(req.condition, req.flags_nzcv);
  assign off = req.offset_up ? req.offset_value : (WordW'(0) - req.offset_value);
  assign addr = req.pre_index ? (req.base_value + off) : req.base_value;
  assign post_addr = req.base_value + off;

  always_comb begin
    case (req.access_size)
      SIZE_BYTE: begin
        be = BE_BYTE;
        sdata = {24'd0, req.store_value[7:0]};
        ldata = {{24{req.sign_extend & req.memory_word[7]}}, req.memory_word[7:0]};
      end
      SIZE_HALF: begin
        be = BE_HALF;
        sdata = {16'd0, req.store_value[15:0]};
        ldata = {{16{req.sign_extend & req.memory_word[15]}}, req.memory_word[15:0]};
      end
      default: begin
        be = BE_WORD;
        sdata = req.store_value;
        ldata = req.memory_word;
      end
    endcase
  end

  always_comb begin
    res = '0;
    if (pass) begin
      res.executed = 1'b1;
      res.access_address = addr;
      res.byte_enable = be;
      res.store_bytes = (req.command == CMD_STORE) ? sdata : '0;
      res.load_result = (req.command == CMD_LOAD) ? ldata : '0;
      res.base_update = !req.pre_index || req.write_back;
      if (req.pre_index) begin
        res.base_new_value = req.write_back ? addr : '0;
      end else begin
        res.base_new_value = post_addr;
      end
      res.user_access = !req.pre_index && req.write_back;
    end
  end

endmodule

// ===== rtl/arm_load_store_unit.sv =====
// Top level of the single load/store unit: input register, execute logic, result register.
//
// One request enters on the s_ group and one result leaves on the m_ group for every
// request. s_tuser carries the command (load or store); s_tdata carries the addressing
// bits, condition, flags, base, offset, store value and the memory word read at the
// address. The result gives the execute flag, effective address, byte enables, store
// lane data, extended load value and the base register writeback.
// A request is registered on acceptance, evaluated by one level of adders and muxes, and
// registered again as the result, which raises m_tvalid when the result register loads.
// Throughput is one request per cycle, since each register hands its request on
// whenever the stage after it is free or being emptied in the same cycle.
// When the receiver holds m_tready low, the result register holds its request and the
// input register still takes one more request; s_tready then drops until the result
// is taken. Reset clears both valid flags, so no result is pending after reset.
// A request whose condition fails still yields a result, with every field zero.
`timescale 1ns / 1ps

module arm_load_store_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tdata from bit 0: access_size[1:0], sign_extend, pre_index, write_back, offset_up,
  // condition[3:0], flags_nzcv[3:0], base_value[31:0], offset_value[31:0],
  // store_value[31:0], memory_word[31:0], zero fill.
  input  logic [alsu_pkg::InDataW-1:0]  s_tdata,
  // tuser: command.
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tdata from bit 0: executed, access_address[31:0], byte_enable[3:0],
  // store_bytes[31:0], load_result[31:0], base_update, base_new_value[31:0],
  // user_access, zero fill.
  output logic [alsu_pkg::OutDataW-1:0] m_tdata
);
  import alsu_pkg::*;

  logic in_valid;
  req_t in_req;
  res_t exec_res;
  logic out_valid;
  res_t out_res;
  logic out_load;

  assign out_load = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req.command <= s_tuser;
      in_req.access_size <= s_tdata[1:0];
      in_req.sign_extend <= s_tdata[2];
      in_req.pre_index <= s_tdata[3];
      in_req.write_back <= s_tdata[4];
      in_req.offset_up <= s_tdata[5];
      in_req.condition <= s_tdata[9:6];
      in_req.flags_nzcv <= s_tdata[13:10];
      in_req.base_value <= s_tdata[45:14];
      in_req.offset_value <= s_tdata[77:46];
      in_req.store_value <= s_tdata[109:78];
      in_req.memory_word <= s_tdata[141:110];
    end
  end

  alsu_exec u_exec (
    .req(in_req),
    .res(exec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= exec_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {1'b0, out_res.user_access, out_res.base_new_value, out_res.base_update,
                    out_res.load_result, out_res.store_bytes, out_res.byte_enable,
                    out_res.access_address, out_res.executed};

endmodule

// ===== dv/arm_load_store_unit_checker.sv =====
// Checker for the load/store unit: watches both streams, predicts each result and compares.
`timescale 1ns / 1ps

module arm_load_store_unit_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [alsu_pkg::InDataW-1:0]  s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [alsu_pkg::OutDataW-1:0] m_tdata,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);
  import alsu_pkg::*;

  res_t expected_results[$];
  int   n_fail = 0;
  int   n_checked = 0;

  function automatic req_t unpack_request(input logic [InDataW-1:0] d, input logic cmd);
    req_t rq;
    rq.command = cmd;
    rq.access_size = d[1:0];
    rq.sign_extend = d[2];
    rq.pre_index = d[3];
    rq.write_back = d[4];
    rq.offset_up = d[5];
    rq.condition = d[9:6];
    rq.flags_nzcv = d[13:10];
    rq.base_value = d[45:14];
    rq.offset_value = d[77:46];
    rq.store_value = d[109:78];
    rq.memory_word = d[141:110];
    return rq;
  endfunction

  function automatic res_t unpack_result(input logic [OutDataW-1:0] d);
    res_t rs;
    rs.executed = d[0];
    rs.access_address = d[32:1];
    rs.byte_enable = d[36:33];
    rs.store_bytes = d[68:37];
    rs.load_result = d[100:69];
    rs.base_update = d[101];
    rs.base_new_value = d[133:102];
    rs.user_access = d[134];
    return rs;
  endfunction

  function automatic res_t compute_access(input req_t rq);
    res_t       rs;
    logic [31:0] off;
    logic       taken;
    logic       n;
    logic       z;
    logic       c;
    logic       v;
    rs = '0;
    {n, z, c, v} = rq.flags_nzcv;
    case (rq.condition)
      COND_EQ: taken = z;
      COND_NE: taken = !z;
      COND_CS: taken = c;
      COND_CC: taken = !c;
      COND_MI: taken = n;
      COND_PL: taken = !n;
      COND_VS: taken = v;
      COND_VC: taken = !v;
      COND_HI: taken = c && !z;
      COND_LS: taken = !c || z;
      COND_GE: taken = (n == v);
      COND_LT: taken = (n != v);
      COND_GT: taken = !z && (n == v);
      COND_LE: taken = z || (n != v);
      COND_AL: taken = 1'b1;
      default: taken = 1'b0;
    endcase
    if (!taken) return rs;
    off = rq.offset_up ? rq.offset_value : 32'd0 - rq.offset_value;
    rs.executed = 1'b1;
    rs.access_address = rq.pre_index ? rq.base_value + off : rq.base_value;
    case (rq.access_size)
      SIZE_BYTE: begin
        rs.byte_enable = BE_BYTE;
        if (rq.command == CMD_STORE) begin
          rs.store_bytes = {24'd0, rq.store_value[7:0]};
        end else begin
          rs.load_result = {{24{rq.sign_extend & rq.memory_word[7]}}, rq.memory_word[7:0]};
        end
      end
      SIZE_HALF: begin
        rs.byte_enable = BE_HALF;
        if (rq.command == CMD_STORE) begin
          rs.store_bytes = {16'd0, rq.store_value[15:0]};
        end else begin
          rs.load_result = {{16{rq.sign_extend & rq.memory_word[15]}},
                            rq.memory_word[15:0]};
        end
      end
      default: begin
        rs.byte_enable = BE_WORD;
        if (rq.command == CMD_STORE) begin
          rs.store_bytes = rq.store_value;
        end else begin
          rs.load_result = rq.memory_word;
        end
      end
    endcase
    if (rq.pre_index) begin
      if (rq.write_back) begin
        rs.base_update = 1'b1;
        rs.base_new_value = rs.access_address;
      end
    end else begin
      rs.base_update = 1'b1;
      rs.base_new_value = rs.access_address + off;
    end
    rs.user_access = !rq.pre_index && rq.write_back;
    return rs;
  endfunction

  task automatic report_mismatch(input string msg);
    n_fail++;
    if (n_fail <= 40) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %h expected %h", n_checked, name, got,
                                want));
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(compute_access(unpack_request(s_tdata, s_tuser)));
      end
      if (m_tvalid && m_tready) begin
        got = unpack_result(m_tdata);
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("executed", 32'(got.executed), 32'(want.executed));
          check_field("access_address", got.access_address, want.access_address);
          check_field("byte_enable", 32'(got.byte_enable), 32'(want.byte_enable));
          check_field("store_bytes", got.store_bytes, want.store_bytes);
          check_field("load_result", got.load_result, want.load_result);
          check_field("base_update", 32'(got.base_update), 32'(want.base_update));
          check_field("base_new_value", got.base_new_value, want.base_new_value);
          check_field("user_access", 32'(got.user_access), 32'(want.user_access));
          n_checked++;
        end
      end
    end
    fail_count <= n_fail;
    pending <= expected_results.size();
    checked <= n_checked;
  end

endmodule

// ===== dv/arm_load_store_unit_tb.sv =====
// Testbench top for the load/store unit: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module arm_load_store_unit_tb;
  import alsu_pkg::*;

  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_RSVD = 2'd3;
  localparam int PhaseCount = 4;
  localparam int PhaseRequests = 125;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  int                  fail_count;
  int                  pending;
  int                  checked;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  n_sent = 0;

  always #10 clk = ~clk;

  arm_load_store_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  arm_load_store_unit_checker u_checker (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .fail_count(fail_count),
    .pending(pending),
    .checked(checked)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic req_t build_request(input logic cmd, input logic [1:0] size,
                                         input logic sext, input logic pre,
                                         input logic wb, input logic up,
                                         input logic [3:0] cond, input logic [3:0] flags,
                                         input logic [31:0] base, input logic [31:0] off,
                                         input logic [31:0] sval, input logic [31:0] mword);
    req_t rq;
    rq.command = cmd;
    rq.access_size = size;
    rq.sign_extend = sext;
    rq.pre_index = pre;
    rq.write_back = wb;
    rq.offset_up = up;
    rq.condition = cond;
    rq.flags_nzcv = flags;
    rq.base_value = base;
    rq.offset_value = off;
    rq.store_value = sval;
    rq.memory_word = mword;
    return rq;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 4095);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 4095);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_request();
    logic [3:0] cond;
    cond = ($urandom_range(0, 99) < 40) ? COND_AL : 4'($urandom_range(0, 15));
    return build_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         cond, 4'($urandom_range(0, 15)), random_word(), random_word(),
                         random_word(), random_word());
  endfunction

  task automatic send_request(input req_t rq);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= rq.command;
    s_tdata <= {2'b00, rq.memory_word, rq.store_value, rq.offset_value, rq.base_value,
                rq.flags_nzcv, rq.condition, rq.offset_up, rq.write_back, rq.pre_index,
                rq.sign_extend, rq.access_size};
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  initial begin
    int         idle_by_phase[PhaseCount];
    int         stall_by_phase[PhaseCount];
    logic [3:0] cc;
    idle_by_phase = '{0, 48, 0, 23};
    stall_by_phase = '{0, 0, 48, 23};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_LOAD;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extension, size and addressing-mode corners with the condition always passing.
    send_request(build_request(CMD_LOAD, SIZE_BYTE, 1'b0, 1'b0, 1'b1, 1'b1, COND_AL, 4'h0,
                               32'h0000_1000, 32'h0000_0FFF, 32'h0, 32'h1234_5680));
    send_request(build_request(CMD_LOAD, SIZE_BYTE, 1'b1, 1'b1, 1'b1, 1'b1, COND_AL, 4'hF,
                               32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1234_5680));
    send_request(build_request(CMD_LOAD, SIZE_HALF, 1'b1, 1'b1, 1'b1, 1'b0, COND_AL, 4'h0,
                               32'h0, 32'h1, 32'h0, 32'h0000_8001));
    send_request(build_request(CMD_LOAD, SIZE_HALF, 1'b0, 1'b1, 1'b0, 1'b0, COND_AL, 4'h0,
                               32'h0000_0100, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_8001));
    send_request(build_request(CMD_LOAD, SIZE_WORD, 1'b1, 1'b0, 1'b0, 1'b0, COND_AL, 4'h0,
                               32'h0000_0100, 32'h8, 32'h0, 32'hFFFF_FFFF));
    send_request(build_request(CMD_LOAD, SIZE_RSVD, 1'b1, 1'b1, 1'b1, 1'b1, COND_AL, 4'h0,
                               32'h8000_0000, 32'h4, 32'h0, 32'hDEAD_BEEF));
    send_request(build_request(CMD_STORE, SIZE_BYTE, 1'b1, 1'b1, 1'b0, 1'b1, COND_AL, 4'h0,
                               32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(build_request(CMD_STORE, SIZE_HALF, 1'b1, 1'b0, 1'b1, 1'b0, COND_AL, 4'h0,
                               32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(build_request(CMD_STORE, SIZE_RSVD, 1'b0, 1'b1, 1'b1, 1'b1, COND_AL, 4'h0,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h0));
    // Every condition code, the never code included, against varied flags.
    for (int c = 0; c < 16; c++) begin
      cc = 4'(c);
      send_request(build_request(cc[0], cc[2:1], cc[3], cc[1], cc[2], cc[0], cc,
                                 4'(c * 7 + 3), 32'h0000_2000 + c, 32'(c), 32'h8765_43F1,
                                 32'hF0F0_8F80));
    end

    for (int p = 0; p < PhaseCount; p++) begin
      send_idle_pct = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      for (int i = 0; i < PhaseRequests; i++) begin
        send_request(random_request());
      end
    end
    s_tvalid <= 1'b0;
    stall_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests (directed corners, all condition codes, random traffic)",
             n_sent);
    $display("under four idle/stall mixes; %0d results compared field by field.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("arm_load_store_unit regression: pass");
    end else begin
      $display("arm_load_store_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timed out with %0d results outstanding.", pending);
    $display("arm_load_store_unit regression: fail");
    $finish;
  end

endmodule
